// File: sv/matrix3_inverse_core_defines.svh
// ----------------------------------------------------------------------------
// matrix3_inverse_core_defines
// Assertion macros shared by the 3x3 inverse core.
// ----------------------------------------------------------------------------
`ifndef MATRIX3_INVERSE_CORE_DEFINES_SVH
`define MATRIX3_INVERSE_CORE_DEFINES_SVH

// same-cycle implication
`define M3I_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define M3I_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared types and cofactor tables for the 3x3 inverse core.
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int N_ELEM = 9;

  // operand indices per adjugate entry: p, q, r, s of p*q - r*s
  localparam int unsigned CF_IDX [N_ELEM][4] = '{
    '{4, 8, 5, 7}, '{1, 8, 2, 7}, '{1, 5, 2, 4},
    '{3, 8, 5, 6}, '{0, 8, 2, 6}, '{0, 5, 2, 3},
    '{3, 7, 4, 6}, '{0, 7, 1, 6}, '{0, 4, 1, 3}
  };

  // entries whose cofactor sign is negative
  localparam logic [N_ELEM-1:0] CF_NEG = 9'b010_101_010;

  // adjugate entries paired with row 0 for the determinant
  localparam int unsigned DET_ADJ [3] = '{0, 3, 6};

  typedef struct packed {
    logic              vld;
    logic              sing;
    logic [N_ELEM-1:0] neg;
    logic [N_ELEM-1:0] ovf;
  } m3i_side_t;

endpackage

// File: sv/m3i_mat_if.sv
// ----------------------------------------------------------------------------
// m3i_mat_if
// Input channel: one 3x3 matrix word.
// ----------------------------------------------------------------------------
interface m3i_mat_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] a_00;
  logic signed [WORD_BITS-1:0] a_01;
  logic signed [WORD_BITS-1:0] a_02;
  logic signed [WORD_BITS-1:0] a_10;
  logic signed [WORD_BITS-1:0] a_11;
  logic signed [WORD_BITS-1:0] a_12;
  logic signed [WORD_BITS-1:0] a_20;
  logic signed [WORD_BITS-1:0] a_21;
  logic signed [WORD_BITS-1:0] a_22;

  modport source (
    output valid, a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22,
    input  ready
  );
  modport sink (
    input  valid, a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22,
    output ready
  );
endinterface

// File: sv/m3i_inv_if.sv
// ----------------------------------------------------------------------------
// m3i_inv_if
// Output channel: one inverse word plus singular flag.
// ----------------------------------------------------------------------------
interface m3i_inv_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] inv_00;
  logic signed [WORD_BITS-1:0] inv_01;
  logic signed [WORD_BITS-1:0] inv_02;
  logic signed [WORD_BITS-1:0] inv_10;
  logic signed [WORD_BITS-1:0] inv_11;
  logic signed [WORD_BITS-1:0] inv_12;
  logic signed [WORD_BITS-1:0] inv_20;
  logic signed [WORD_BITS-1:0] inv_21;
  logic signed [WORD_BITS-1:0] inv_22;
  logic                        singular;

  modport source (
    output valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
           inv_20, inv_21, inv_22, singular,
    input  ready
  );
  modport sink (
    input  valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
           inv_20, inv_21, inv_22, singular,
    output ready
  );
endinterface

// File: sv/m3i_div.sv
// ----------------------------------------------------------------------------
// m3i_div
// Pipelined restoring divider, nine lanes sharing one divisor, one quotient
// bit per stage, WORD_BITS stages.
// ----------------------------------------------------------------------------
module m3i_div import m3i_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int REM_BITS  = 130
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [REM_BITS-1:0]  num_i [N_ELEM],
  input  logic [REM_BITS-1:0]  dsor_i,
  input  m3i_side_t            side_i,
  output logic [WORD_BITS-1:0] quo_o [N_ELEM],
  output m3i_side_t            side_o
);

  logic [REM_BITS-1:0]  rem_w  [WORD_BITS][N_ELEM];
  logic [REM_BITS-1:0]  dsor_w [WORD_BITS];
  logic [WORD_BITS-1:0] quo_w  [WORD_BITS+1][N_ELEM];
  m3i_side_t            side_w [WORD_BITS+1];

  always_comb begin
    for (int j = 0; j < N_ELEM; j++) begin
      rem_w[0][j] = num_i[j];
      quo_w[0][j] = '0;
    end
    dsor_w[0] = dsor_i;
    side_w[0] = side_i;
  end

  for (genvar k = 0; k < WORD_BITS; k++) begin : g_stg
    localparam int BI = WORD_BITS - 1 - k;

    logic [REM_BITS-1:0]  tgt;
    logic [N_ELEM-1:0]    ge;
    logic [WORD_BITS-1:0] quo_d [N_ELEM];
    logic [WORD_BITS-1:0] quo_q [N_ELEM];
    m3i_side_t            side_q;

    assign tgt = dsor_w[k] << BI;

    always_comb begin
      for (int j = 0; j < N_ELEM; j++) begin
        ge[j]        = rem_w[k][j] >= tgt;
        quo_d[j]     = quo_w[k][j];
        quo_d[j][BI] = ge[j];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q <= '0;
      end else if (en_i) begin
        side_q <= side_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q <= quo_d;
      end
    end

    always_comb begin
      for (int j = 0; j < N_ELEM; j++) begin
        quo_w[k+1][j] = quo_q[j];
      end
      side_w[k+1] = side_q;
    end

    if (k < WORD_BITS - 1) begin : g_fwd
      logic [REM_BITS-1:0] rem_d [N_ELEM];
      logic [REM_BITS-1:0] rem_q [N_ELEM];
      logic [REM_BITS-1:0] dsor_q;

      always_comb begin
        for (int j = 0; j < N_ELEM; j++) begin
          rem_d[j] = ge[j] ? (rem_w[k][j] - tgt) : rem_w[k][j];
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q  <= rem_d;
          dsor_q <= dsor_w[k];
        end
      end

      always_comb begin
        for (int j = 0; j < N_ELEM; j++) begin
          rem_w[k+1][j] = rem_q[j];
        end
        dsor_w[k+1] = dsor_q;
      end
    end
  end

  assign quo_o  = quo_w[WORD_BITS];
  assign side_o = side_w[WORD_BITS];

endmodule

// File: sv/matrix3_inverse_core.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_core
// Inverse of a 3x3 signed fixed-point matrix by adjugate and determinant.
// ----------------------------------------------------------------------------
// Usage:
//   mat_i takes one matrix word (nine signed Q elements); inv_o returns the
//   inverse word, each element rounded to nearest (ties away from zero) and
//   saturated, plus a singular flag. A zero determinant gives singular = 1
//   and all nine elements zero.
// Pipeline, from accept to inv_o.valid:
//   input register, products, adjugate, determinant partial products,
//   determinant sum, numerator set-up, WORD_BITS divider stages (one
//   quotient bit each), output register.
// Throughput: one word per cycle while inv_o is not stalled, set by the fully pipelined divider.
// Stall: all stages advance together; while inv_o holds an untaken word,
//   mat_i.ready is low and every stage keeps its contents.
// Reset: clears the valid bits and side flags only; no state survives between words.
// ----------------------------------------------------------------------------
`include "matrix3_inverse_core_defines.svh"

module matrix3_inverse_core import m3i_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input logic         clk_i,
  input logic         rst_ni,
  m3i_mat_if.sink     mat_i,
  m3i_inv_if.source   inv_o
);

  localparam int W   = WORD_BITS;
  localparam int PW  = 2 * W;
  localparam int AW  = 2 * W + 1;
  localparam int DW  = 3 * W + 1;
  localparam int NW0 = (2 * W + 2 * FRAC_BITS + 1) > 3 * W ?
                       (2 * W + 2 * FRAC_BITS + 1) : 3 * W;
  localparam int NW  = NW0 + 1;
  localparam int CW  = NW > (4 * W + 1) ? NW : (4 * W + 1);
  localparam int NST = 5;

  localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

  logic           en;
  logic [NST-1:0] vld_q;
  logic           vld_out_q;

  assign en          = !vld_out_q || inv_o.ready;
  assign mat_i.ready = en;

  // s0: input
  logic signed [W-1:0] a_in [N_ELEM];
  logic signed [W-1:0] a_q  [N_ELEM];

  assign a_in[0] = mat_i.a_00;
  assign a_in[1] = mat_i.a_01;
  assign a_in[2] = mat_i.a_02;
  assign a_in[3] = mat_i.a_10;
  assign a_in[4] = mat_i.a_11;
  assign a_in[5] = mat_i.a_12;
  assign a_in[6] = mat_i.a_20;
  assign a_in[7] = mat_i.a_21;
  assign a_in[8] = mat_i.a_22;

  // s1: cofactor products
  logic signed [PW-1:0] pp_d  [2*N_ELEM];
  logic signed [PW-1:0] pp_q  [2*N_ELEM];
  logic signed [W-1:0]  r0_s1 [3];

  always_comb begin
    for (int j = 0; j < N_ELEM; j++) begin
      pp_d[2*j]   = PW'(a_q[CF_IDX[j][0]]) * PW'(a_q[CF_IDX[j][1]]);
      pp_d[2*j+1] = PW'(a_q[CF_IDX[j][2]]) * PW'(a_q[CF_IDX[j][3]]);
    end
  end

  // s2: adjugate
  logic signed [AW-1:0] adj_d  [N_ELEM];
  logic signed [AW-1:0] adj_q  [N_ELEM];
  logic signed [W-1:0]  r0_s2  [3];

  always_comb begin
    for (int j = 0; j < N_ELEM; j++) begin
      if (CF_NEG[j]) begin
        adj_d[j] = AW'(pp_q[2*j+1]) - AW'(pp_q[2*j]);
      end else begin
        adj_d[j] = AW'(pp_q[2*j]) - AW'(pp_q[2*j+1]);
      end
    end
  end

  // s3: determinant partial products, adjugate split at W bits
  logic signed [AW-1:0] pl_d   [3];
  logic signed [AW-1:0] ph_d   [3];
  logic signed [AW-1:0] pl_q   [3];
  logic signed [AW-1:0] ph_q   [3];
  logic signed [AW-1:0] adj_s3 [N_ELEM];

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      pl_d[t] = AW'(r0_s2[t]) * AW'($signed({1'b0, adj_q[DET_ADJ[t]][W-1:0]}));
      ph_d[t] = AW'(r0_s2[t]) * AW'($signed(adj_q[DET_ADJ[t]][AW-1:W]));
    end
  end

  // s4: determinant
  logic signed [DW-1:0] det_d;
  logic signed [DW-1:0] det_q;
  logic signed [AW-1:0] adj_s4 [N_ELEM];

  always_comb begin
    det_d = '0;
    for (int t = 0; t < 3; t++) begin
      det_d = det_d + $signed({ph_q[t], {W{1'b0}}}) + DW'(pl_q[t]);
    end
  end

  // s5: magnitudes, numerator 2n*2^2F + d, divisor 2d, overflow
  logic [DW-1:0]   dmag;
  logic [AW-1:0]   nmag  [N_ELEM];
  logic [CW-1:0]   num_d [N_ELEM];
  logic [CW-1:0]   num_q [N_ELEM];
  logic [CW-1:0]   dsor_d;
  logic [CW-1:0]   dsor_q;
  logic [CW-1:0]   lim_w;
  m3i_side_t       side_d;
  m3i_side_t       side_q;

  always_comb begin
    dmag        = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
    dsor_d      = CW'(dmag) << 1;
    lim_w       = CW'(dmag) << (W + 1);
    side_d.vld  = vld_q[4];
    side_d.sing = det_q == '0;
    for (int j = 0; j < N_ELEM; j++) begin
      nmag[j]       = adj_s4[j][AW-1] ? AW'(-adj_s4[j]) : AW'(adj_s4[j]);
      num_d[j]      = (CW'(nmag[j]) << (2 * FRAC_BITS + 1)) + CW'(dmag);
      side_d.neg[j] = adj_s4[j][AW-1] ^ det_q[DW-1];
      side_d.ovf[j] = num_d[j] >= lim_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      side_q <= '0;
    end else if (en) begin
      vld_q  <= {vld_q[NST-2:0], mat_i.valid};
      side_q <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q    <= a_in;
      pp_q   <= pp_d;
      r0_s1  <= a_q[0:2];
      adj_q  <= adj_d;
      r0_s2  <= r0_s1;
      pl_q   <= pl_d;
      ph_q   <= ph_d;
      adj_s3 <= adj_q;
      det_q  <= det_d;
      adj_s4 <= adj_s3;
      num_q  <= num_d;
      dsor_q <= dsor_d;
    end
  end

  // divider
  logic [W-1:0] quo   [N_ELEM];
  m3i_side_t    side_dv;

  m3i_div #(
    .WORD_BITS (W),
    .REM_BITS  (CW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .num_i  (num_q),
    .dsor_i (dsor_q),
    .side_i (side_q),
    .quo_o  (quo),
    .side_o (side_dv)
  );

  // output: saturate, sign, singular
  logic [W-1:0] lim   [N_ELEM];
  logic [W-1:0] mag   [N_ELEM];
  logic [W-1:0] inv_d [N_ELEM];
  logic [W-1:0] inv_q [N_ELEM];
  logic         sing_q;

  always_comb begin
    for (int j = 0; j < N_ELEM; j++) begin
      lim[j] = side_dv.neg[j] ? MINN : MAXP;
      mag[j] = (side_dv.ovf[j] || quo[j] > lim[j]) ? lim[j] : quo[j];
      if (side_dv.sing) begin
        inv_d[j] = '0;
      end else begin
        inv_d[j] = side_dv.neg[j] ? W'(-mag[j]) : mag[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (en) begin
      vld_out_q <= side_dv.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inv_q  <= inv_d;
      sing_q <= side_dv.sing;
    end
  end

  assign inv_o.valid    = vld_out_q;
  assign inv_o.inv_00   = inv_q[0];
  assign inv_o.inv_01   = inv_q[1];
  assign inv_o.inv_02   = inv_q[2];
  assign inv_o.inv_10   = inv_q[3];
  assign inv_o.inv_11   = inv_q[4];
  assign inv_o.inv_12   = inv_q[5];
  assign inv_o.inv_20   = inv_q[6];
  assign inv_o.inv_21   = inv_q[7];
  assign inv_o.inv_22   = inv_q[8];
  assign inv_o.singular = sing_q;

  `M3I_ASSERT_SAME(a_sing_zero, clk_i, rst_ni, inv_o.valid && inv_o.singular, inv_q[0] == '0 && inv_q[1] == '0 && inv_q[2] == '0 && inv_q[3] == '0 && inv_q[4] == '0 && inv_q[5] == '0 && inv_q[6] == '0 && inv_q[7] == '0 && inv_q[8] == '0, "singular word with nonzero element")
  `M3I_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, !en, $stable(vld_q) && $stable(side_q) && $stable(vld_out_q), "pipeline moved during stall")
  `M3I_ASSERT_NEXT(a_accept_enter, clk_i, rst_ni, mat_i.valid && mat_i.ready, vld_q[0], "accepted word not captured")

endmodule

// File: sim/matrix3_inverse_core_tb.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_core_tb
// Self-checking bench for the 3x3 fixed-point inverse core: directed and
// random matrices go in under several idle and stall patterns, and every
// returned word is compared against an exact wide-integer inverse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix3_inverse_core_tb;

  localparam int WB = 32;
  localparam int FB = 16;
  localparam int N_RAND = 1000;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;

  typedef logic signed [191:0] wide_t;
  typedef logic [191:0] uwide_t;

  typedef struct {
    logic signed [WB-1:0] a [9];
  } matrix_t;

  typedef struct {
    logic [WB-1:0] v [9];
    logic          sing;
  } inverse_t;

  typedef enum int {MODE_FREE, MODE_SRC_IDLE, MODE_SNK_STALL, MODE_BOTH} mode_e;

  class inverse_scoreboard;
    inverse_t pending [$];
    int errors;

    function inverse_t invert_matrix(matrix_t m);
      wide_t    e [9];
      wide_t    adj [9];
      wide_t    det;
      uwide_t   num, den, quo, lim;
      logic     neg;
      inverse_t r;
      for (int i = 0; i < 9; i++) e[i] = wide_t'(m.a[i]);
      adj[0] =   e[4] * e[8] - e[5] * e[7];
      adj[1] = -(e[1] * e[8] - e[2] * e[7]);
      adj[2] =   e[1] * e[5] - e[2] * e[4];
      adj[3] = -(e[3] * e[8] - e[5] * e[6]);
      adj[4] =   e[0] * e[8] - e[2] * e[6];
      adj[5] = -(e[0] * e[5] - e[2] * e[3]);
      adj[6] =   e[3] * e[7] - e[4] * e[6];
      adj[7] = -(e[0] * e[7] - e[1] * e[6]);
      adj[8] =   e[0] * e[4] - e[1] * e[3];
      det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
      r.sing = (det == 0);
      for (int i = 0; i < 9; i++) begin
        if (r.sing) begin
          r.v[i] = '0;
        end else begin
          neg = (adj[i] < 0) != (det < 0);
          num = (adj[i] < 0) ? uwide_t'(-adj[i]) : uwide_t'(adj[i]);
          den = (det < 0) ? uwide_t'(-det) : uwide_t'(det);
          // round half away: (2n + d) / 2d
          num = (num << (2 * FB + 1)) + den;
          quo = num / (den << 1);
          lim = (uwide_t'(1) << (WB - 1)) - (neg ? 0 : 1);
          if (quo > lim) quo = lim;
          r.v[i] = neg ? WB'(-quo) : WB'(quo);
        end
      end
      return r;
    endfunction

    function void note_matrix(matrix_t m);
      pending.push_back(invert_matrix(m));
    endfunction

    task report(string what, logic [WB-1:0] got, logic [WB-1:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_inverse(inverse_t got);
      inverse_t want;
      if (pending.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        want = pending.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.v[i] !== want.v[i]) report($sformatf("inv[%0d]", i), got.v[i], want.v[i]);
        if (got.sing !== want.sing) report("singular", got.sing, want.sing);
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  mode_e mode;
  logic hold_req;
  inverse_scoreboard sb;

  m3i_mat_if #(.WORD_BITS(WB)) mat_if ();
  m3i_inv_if #(.WORD_BITS(WB)) inv_if ();

  matrix3_inverse_core #(.WORD_BITS(WB), .FRAC_BITS(FB)) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .mat_i (mat_if),
    .inv_o (inv_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("matrix3_inverse_core_tb NOT OK");
      $finish;
    end
  end

  function automatic logic signed [WB-1:0] rand_elem(int kind);
    case (kind)
      0: rand_elem = $urandom;
      1: rand_elem = ($signed($urandom_range(0, 16)) - 8) <<< FB;
      2: rand_elem = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: rand_elem = $urandom_range(0, 3) == 0 ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endcase
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    int kind;
    int pick;
    kind = $urandom_range(0, 9);
    pick = (kind < 3) ? 0 : (kind < 6) ? 1 : (kind < 8) ? 2 : 3;
    for (int i = 0; i < 9; i++) m.a[i] = rand_elem(pick);
    if (kind == 9) begin
      // singular: copy a row or a column onto another
      if ($urandom_range(0, 1)) begin
        for (int c = 0; c < 3; c++) m.a[3 + c] = m.a[c];
      end else begin
        for (int r = 0; r < 3; r++) m.a[r * 3 + 2] = m.a[r * 3];
      end
    end
    return m;
  endfunction

  function automatic matrix_t diag_matrix(logic signed [WB-1:0] x, logic signed [WB-1:0] y,
                                          logic signed [WB-1:0] z);
    matrix_t m;
    for (int i = 0; i < 9; i++) m.a[i] = '0;
    m.a[0] = x;
    m.a[4] = y;
    m.a[8] = z;
    return m;
  endfunction

  task automatic send_matrix(matrix_t m);
    while ((mode == MODE_SRC_IDLE && $urandom_range(0, 99) < 83) ||
           (mode == MODE_BOTH && $urandom_range(0, 99) < 16)) begin
      mat_if.valid = 1'b0;
      @(negedge clk);
    end
    mat_if.valid = 1'b1;
    mat_if.a_00 = m.a[0];
    mat_if.a_01 = m.a[1];
    mat_if.a_02 = m.a[2];
    mat_if.a_10 = m.a[3];
    mat_if.a_11 = m.a[4];
    mat_if.a_12 = m.a[5];
    mat_if.a_20 = m.a[6];
    mat_if.a_21 = m.a[7];
    mat_if.a_22 = m.a[8];
    do @(posedge clk); while (!mat_if.ready);
    sb.note_matrix(m);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      inv_if.ready = 1'b0;
    end else if (hold_req) begin
      inv_if.ready = 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 1'b0;
    end else begin
      case (mode)
        MODE_SNK_STALL: inv_if.ready = ($urandom_range(0, 99) >= 83);
        MODE_BOTH:      inv_if.ready = ($urandom_range(0, 99) >= 16);
        default:        inv_if.ready = 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    inverse_t got;
    if (rst_n && inv_if.valid && inv_if.ready) begin
      got.v[0] = inv_if.inv_00;
      got.v[1] = inv_if.inv_01;
      got.v[2] = inv_if.inv_02;
      got.v[3] = inv_if.inv_10;
      got.v[4] = inv_if.inv_11;
      got.v[5] = inv_if.inv_12;
      got.v[6] = inv_if.inv_20;
      got.v[7] = inv_if.inv_21;
      got.v[8] = inv_if.inv_22;
      got.sing = inv_if.singular;
      sb.check_inverse(got);
    end
  end

  initial begin
    matrix_t m;
    sb = new();
    cycles = 0;
    mode = MODE_FREE;
    hold_req = 1'b0;
    rst_n = 1'b0;
    mat_if.valid = 1'b0;
    mat_if.a_00 = '0;
    mat_if.a_01 = '0;
    mat_if.a_02 = '0;
    mat_if.a_10 = '0;
    mat_if.a_11 = '0;
    mat_if.a_12 = '0;
    mat_if.a_20 = '0;
    mat_if.a_21 = '0;
    mat_if.a_22 = '0;
    inv_if.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: identity, scaled diagonals, extremes, singular, saturation
    send_matrix(diag_matrix(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
    send_matrix(diag_matrix(32'sh0002_0000, 32'sh0000_8000, -32'sh0004_0000));
    send_matrix(diag_matrix(32'sh0003_0000, 32'sh0007_0000, -32'sh0000_3000));
    send_matrix(diag_matrix(32'sh0000_0000, 32'sh0001_0000, 32'sh0001_0000));
    send_matrix(diag_matrix(32'sh0000_0001, 32'sh0001_0000, 32'sh0001_0000));
    send_matrix(diag_matrix(-32'sh0000_0001, 32'sh0000_0001, 32'sh0001_0000));
    send_matrix(diag_matrix(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
    send_matrix(diag_matrix(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_matrix(diag_matrix(32'sh8000_0000, 32'sh0001_0000, 32'sh0001_0000));
    send_matrix(diag_matrix(32'sh0000_0003, 32'sh0000_0005, 32'sh0001_0000));
    for (int i = 0; i < 9; i++) m.a[i] = '0;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m.a[i] = 32'sh7fff_ffff;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m.a[i] = 32'sh8000_0000;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m.a[i] = (i % 2) ? 32'sh8000_0000 : 32'sh7fff_ffff;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m.a[i] = (i + 1) <<< FB;
    send_matrix(m);
    m.a[8] = 10 <<< FB;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m.a[i] = (i == 2 || i == 4 || i == 6) ? 32'sh0001_0000 : '0;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m.a[i] = (i == 1 || i == 5 || i == 6) ? -32'sh0001_0000 : '0;
    send_matrix(m);

    // random phases
    for (int ph = 0; ph < 5; ph++) begin
      mode = (ph == 4) ? MODE_FREE : mode_e'(ph);
      if (ph == 4) hold_req = 1'b1;
      for (int k = 0; k < N_RAND / 5; k++) send_matrix(rand_matrix());
      mat_if.valid = 1'b0;
    end
    mode = MODE_FREE;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("matrix3_inverse_core_tb OK");
    end else begin
      $display("matrix3_inverse_core_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/m3i_pkg.sv
sv/m3i_mat_if.sv
sv/m3i_inv_if.sv
sv/m3i_div.sv
sv/matrix3_inverse_core.sv
sim/matrix3_inverse_core_tb.sv
